// ----- src/sgc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and fixed constants for the slab geometry calculator.
// No dependencies.
package sgc_pkg;

  localparam int SIZE_W = 16;
  localparam int OBJ_W = 13;
  localparam int ORD_W = 2;
  localparam int WASTE_W = 7;

  localparam int MIN_SLOT_SHIFT = 3;
  localparam int MAX_SLOT_SHIFT = 12;
  localparam int SMALL_SHIFT = 3;
  localparam int WASTE_LIMIT = 13;
  localparam int PCT_SCALE = 100;
  localparam int OBJ_MAX = 8191;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_ALIGN = 2'd1,
    ST_TOO_LARGE = 2'd2,
    ST_ZERO      = 2'd3
  } status_t;

  typedef struct packed {
    logic    valid;
    status_t status;
  } ctl_t;

endpackage

// ----- src/sgc_prep.sv -----
`timescale 1ns / 1ps
// Front stage: alignment checks, align-up, rounding to a power of two,
// and the seed of the division chain. Depends on sgc_pkg.
module sgc_prep #(
  parameter int QW = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           round_en,
  input  logic                           req_valid,
  input  logic [sgc_pkg::SIZE_W-1:0]     object_size,
  input  logic [sgc_pkg::SIZE_W-1:0]     alignment,
  output logic                           up_ready,
  input  logic                           dn_ready,
  output sgc_pkg::ctl_t                  ctl,
  output logic [sgc_pkg::SIZE_W-1:0]     slot,
  output logic [sgc_pkg::SIZE_W-1:0]     rem,
  output logic [QW-1:0]                  quo
);

  localparam logic [15:0] MIN_SLOT = 16'(1 << sgc_pkg::MIN_SLOT_SHIFT);
  localparam logic [16:0] MAX_SLOT = 17'(1 << sgc_pkg::MAX_SLOT_SHIFT);

  logic              vld;
  sgc_pkg::status_t  status;
  logic [15:0]       align_m1;
  logic [16:0]       sum;
  logic [16:0]       aligned;
  logic [15:0]       clamped;
  logic [15:0]       smear;
  logic [15:0]       pow2;
  logic [15:0]       slot_sel;
  sgc_pkg::status_t  st;

  always_comb begin
    align_m1 = alignment - 16'd1;
    sum      = {1'b0, object_size} + {1'b0, align_m1};
    aligned  = sum & ~{1'b0, align_m1};
    if (aligned[15:0] < MIN_SLOT) begin
      clamped = MIN_SLOT;
    end else begin
      clamped = aligned[15:0];
    end
    smear = clamped - 16'd1;
    smear = smear | (smear >> 1);
    smear = smear | (smear >> 2);
    smear = smear | (smear >> 4);
    smear = smear | (smear >> 8);
    pow2  = smear + 16'd1;
    slot_sel = round_en ? pow2 : aligned[15:0];
    if (alignment == 16'd0 || (alignment & align_m1) != 16'd0) begin
      st = sgc_pkg::ST_BAD_ALIGN;
    end else if (object_size == 16'd0) begin
      st = sgc_pkg::ST_ZERO;
    end else if (aligned[16]) begin
      st = sgc_pkg::ST_TOO_LARGE;
    end else if (round_en && aligned > MAX_SLOT) begin
      st = sgc_pkg::ST_TOO_LARGE;
    end else begin
      st = sgc_pkg::ST_OK;
    end
  end

  assign up_ready = !vld || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (up_ready) begin
      vld <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && req_valid) begin
      status <= st;
      slot   <= slot_sel;
      rem    <= (slot_sel == 16'd1) ? 16'd0 : 16'd1;
      quo    <= QW'(slot_sel == 16'd1);
    end
  end

  assign ctl.valid  = vld;
  assign ctl.status = status;

endmodule

// ----- src/sgc_div_cell.sv -----
`timescale 1ns / 1ps
// One restoring-division cell: doubles the remainder of 2^STEP by the slot
// and shifts in one quotient bit; latches order taps. Depends on sgc_pkg.
module sgc_div_cell #(
  parameter int STEP = 1,
  parameter int BASE = 12,
  parameter int NORD = 4,
  parameter int QW   = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  sgc_pkg::ctl_t                          up_ctl,
  input  logic [sgc_pkg::SIZE_W-1:0]             up_slot,
  input  logic [sgc_pkg::SIZE_W-1:0]             up_rem,
  input  logic [QW-1:0]                          up_quo,
  input  logic [NORD-1:0][sgc_pkg::SIZE_W-1:0]   up_taps,
  output logic                                   up_ready,
  input  logic                                   dn_ready,
  output sgc_pkg::ctl_t                          ctl,
  output logic [sgc_pkg::SIZE_W-1:0]             slot,
  output logic [sgc_pkg::SIZE_W-1:0]             rem,
  output logic [QW-1:0]                          quo,
  output logic [NORD-1:0][sgc_pkg::SIZE_W-1:0]   taps
);

  logic                                  vld;
  sgc_pkg::status_t                      status;
  logic [16:0]                           dbl;
  logic [16:0]                           diff;
  logic                                  ge;
  logic [15:0]                           rem_new;
  logic [NORD-1:0][sgc_pkg::SIZE_W-1:0]  taps_new;

  always_comb begin
    dbl     = {up_rem, 1'b0};
    diff    = dbl - {1'b0, up_slot};
    ge      = dbl >= {1'b0, up_slot};
    rem_new = ge ? diff[15:0] : dbl[15:0];
    for (int o = 0; o < NORD; o++) begin
      taps_new[o] = (STEP == BASE + o) ? rem_new : up_taps[o];
    end
  end

  assign up_ready = !vld || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (up_ready) begin
      vld <= up_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_ctl.valid) begin
      status <= up_ctl.status;
      slot   <= up_slot;
      rem    <= rem_new;
      quo    <= {up_quo[QW-2:0], ge};
      taps   <= taps_new;
    end
  end

  assign ctl.valid  = vld;
  assign ctl.status = status;

endmodule

// ----- src/sgc_order_sel.sv -----
`timescale 1ns / 1ps
// Back end: per-order waste and slot counts, then order choice and the
// output register. Depends on sgc_pkg.
module sgc_order_sel #(
  parameter int PAGE_SHIFT = 12,
  parameter int BASE       = 12,
  parameter int NORD       = 4,
  parameter int N          = 15,
  parameter int QW         = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  sgc_pkg::ctl_t                          up_ctl,
  input  logic [sgc_pkg::SIZE_W-1:0]             up_slot,
  input  logic [QW-1:0]                          up_quo,
  input  logic [NORD-1:0][sgc_pkg::SIZE_W-1:0]   up_taps,
  output logic                                   up_ready,
  output logic                                   rsp_valid,
  input  logic                                   rsp_stall,
  output logic [1:0]                             status,
  output logic [sgc_pkg::SIZE_W-1:0]             slot_size,
  output logic [sgc_pkg::OBJ_W-1:0]              objects_per_slab,
  output logic [sgc_pkg::ORD_W-1:0]              slab_order
);

  localparam int EW = (QW > sgc_pkg::OBJ_W) ? QW : sgc_pkg::OBJ_W;
  localparam int OW = (NORD > 1) ? $clog2(NORD) : 1;
  localparam logic [16:0] SMALL_LIM = 17'((1 << PAGE_SHIFT) >> sgc_pkg::SMALL_SHIFT);

  function automatic logic [sgc_pkg::OBJ_W-1:0] sat_objs(input logic [QW-1:0] q);
    logic [EW-1:0] qe;
    qe = EW'(q);
    return (qe > EW'(sgc_pkg::OBJ_MAX)) ? sgc_pkg::OBJ_W'(sgc_pkg::OBJ_MAX)
                                        : qe[sgc_pkg::OBJ_W-1:0];
  endfunction

  // stage A
  logic                                          a_vld;
  sgc_pkg::status_t                              a_status;
  logic [sgc_pkg::SIZE_W-1:0]                    a_slot;
  logic                                          a_small;
  logic [sgc_pkg::OBJ_W-1:0]                     a_objs_small;
  logic [NORD-1:0]                               a_fit;
  logic [NORD-1:0][sgc_pkg::OBJ_W-1:0]           a_objs;
  logic [NORD-1:0][sgc_pkg::WASTE_W-1:0]         a_waste;

  logic [NORD-1:0]                               fit_c;
  logic [NORD-1:0][sgc_pkg::OBJ_W-1:0]           objs_c;
  logic [NORD-1:0][sgc_pkg::WASTE_W-1:0]         waste_c;
  logic [QW-1:0]                                 q_o;
  logic [22:0]                                   prod;
  logic                                          a_ready;

  always_comb begin
    for (int o = 0; o < NORD; o++) begin
      q_o        = up_quo >> (N - BASE - o);
      fit_c[o]   = |q_o;
      objs_c[o]  = sat_objs(q_o);
      prod       = 23'(up_taps[o]) * 23'(sgc_pkg::PCT_SCALE);
      waste_c[o] = sgc_pkg::WASTE_W'(prod >> (BASE + o));
    end
  end

  assign a_ready  = !rsp_valid || !rsp_stall;
  assign up_ready = !a_vld || a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (up_ready) begin
      a_vld <= up_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_ctl.valid) begin
      a_status     <= up_ctl.status;
      a_slot       <= up_slot;
      a_small      <= {1'b0, up_slot} < SMALL_LIM;
      a_objs_small <= sat_objs(up_quo >> (N - PAGE_SHIFT));
      a_fit        <= fit_c;
      a_objs       <= objs_c;
      a_waste      <= waste_c;
    end
  end

  // stage B: order choice
  logic                          found;
  logic                          have_best;
  logic [sgc_pkg::WASTE_W-1:0]   best_w;
  logic [sgc_pkg::OBJ_W-1:0]     best_objs;
  logic [OW-1:0]                 best_ord;
  logic [sgc_pkg::OBJ_W-1:0]     sel_objs;
  logic [OW-1:0]                 sel_ord;
  sgc_pkg::status_t              st_c;

  always_comb begin
    found     = 1'b0;
    have_best = 1'b0;
    best_w    = sgc_pkg::WASTE_W'(sgc_pkg::PCT_SCALE);
    best_objs = '0;
    best_ord  = '0;
    sel_objs  = '0;
    sel_ord   = '0;
    if (a_small) begin
      found    = 1'b1;
      sel_objs = a_objs_small;
    end else begin
      for (int o = 0; o < NORD; o++) begin
        if (a_fit[o] && !found) begin
          if (a_waste[o] < sgc_pkg::WASTE_W'(sgc_pkg::WASTE_LIMIT)) begin
            found    = 1'b1;
            sel_objs = a_objs[o];
            sel_ord  = OW'(o);
          end else if (a_waste[o] < best_w) begin
            have_best = 1'b1;
            best_w    = a_waste[o];
            best_objs = a_objs[o];
            best_ord  = OW'(o);
          end
        end
      end
      if (!found && have_best) begin
        found    = 1'b1;
        sel_objs = best_objs;
        sel_ord  = best_ord;
      end
    end
    if (a_status != sgc_pkg::ST_OK) begin
      st_c = a_status;
    end else if (!found) begin
      st_c = sgc_pkg::ST_TOO_LARGE;
    end else begin
      st_c = sgc_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (a_ready) begin
      rsp_valid <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && a_vld) begin
      status <= st_c;
      if (st_c == sgc_pkg::ST_OK) begin
        slot_size        <= a_slot;
        objects_per_slab <= sel_objs;
        slab_order       <= sgc_pkg::ORD_W'(sel_ord);
      end else begin
        slot_size        <= '0;
        objects_per_slab <= '0;
        slab_order       <= '0;
      end
    end
  end

endmodule

// ----- src/slab_geometry_calculator.sv -----
`timescale 1ns / 1ps
// Registers in order: sgc_prep, the division cells, then stage A and the output of sgc_order_sel.
// Throughput: one transaction per cycle without rsp_stall; a chain of restoring-division
// cells, one per quotient bit of 2^k / slot, carries each request, later ones behind it.
// Reset (rst, synchronous): empties every stage and sets round_to_power_of_two to 1.
// Depends on sgc_pkg, sgc_prep, sgc_div_cell, sgc_order_sel.
module slab_geometry_calculator #(
  parameter int PAGE_SHIFT       = 12,
  parameter int BASE_ORDER_SHIFT = 12,
  parameter int MAX_PAGE_ORDER   = 3
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  logic [sgc_pkg::SIZE_W-1:0]         object_size,
  input  logic [sgc_pkg::SIZE_W-1:0]         alignment,
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output logic [1:0]                         status,
  output logic [sgc_pkg::SIZE_W-1:0]         slot_size,
  output logic [sgc_pkg::OBJ_W-1:0]          objects_per_slab,
  output logic [sgc_pkg::ORD_W-1:0]          slab_order,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_data
);

  localparam int NORD = MAX_PAGE_ORDER + 1;
  localparam int TOP  = BASE_ORDER_SHIFT + MAX_PAGE_ORDER;
  localparam int N    = (TOP > PAGE_SHIFT) ? TOP : PAGE_SHIFT;
  localparam int QW   = N + 1;

  logic round_to_power_of_two;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      round_to_power_of_two <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      round_to_power_of_two <= cfg_data;
    end
  end

  sgc_pkg::ctl_t                           ctl_s  [0:N];
  logic [sgc_pkg::SIZE_W-1:0]              slot_s [0:N];
  logic [sgc_pkg::SIZE_W-1:0]              rem_s  [0:N];
  logic [QW-1:0]                           quo_s  [0:N];
  logic [NORD-1:0][sgc_pkg::SIZE_W-1:0]    taps_s [0:N];
  logic                                    rdy_s  [0:N+1];

  assign req_stall = !rdy_s[0];
  assign taps_s[0] = '0;

  sgc_prep #(
    .QW(QW)
  ) u_prep (
    .clk        (clk),
    .rst        (rst),
    .round_en   (round_to_power_of_two),
    .req_valid  (req_valid),
    .object_size(object_size),
    .alignment  (alignment),
    .up_ready   (rdy_s[0]),
    .dn_ready   (rdy_s[1]),
    .ctl        (ctl_s[0]),
    .slot       (slot_s[0]),
    .rem        (rem_s[0]),
    .quo        (quo_s[0])
  );

  for (genvar j = 1; j <= N; j++) begin : g_cell
    sgc_div_cell #(
      .STEP(j),
      .BASE(BASE_ORDER_SHIFT),
      .NORD(NORD),
      .QW  (QW)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .up_ctl  (ctl_s[j-1]),
      .up_slot (slot_s[j-1]),
      .up_rem  (rem_s[j-1]),
      .up_quo  (quo_s[j-1]),
      .up_taps (taps_s[j-1]),
      .up_ready(rdy_s[j]),
      .dn_ready(rdy_s[j+1]),
      .ctl     (ctl_s[j]),
      .slot    (slot_s[j]),
      .rem     (rem_s[j]),
      .quo     (quo_s[j]),
      .taps    (taps_s[j])
    );
  end

  sgc_order_sel #(
    .PAGE_SHIFT(PAGE_SHIFT),
    .BASE      (BASE_ORDER_SHIFT),
    .NORD      (NORD),
    .N         (N),
    .QW        (QW)
  ) u_sel (
    .clk             (clk),
    .rst             (rst),
    .up_ctl          (ctl_s[N]),
    .up_slot         (slot_s[N]),
    .up_quo          (quo_s[N]),
    .up_taps         (taps_s[N]),
    .up_ready        (rdy_s[N+1]),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .status          (status),
    .slot_size       (slot_size),
    .objects_per_slab(objects_per_slab),
    .slab_order      (slab_order)
  );

endmodule

// ----- src/sgc_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for slab_geometry_calculator, bound to the top level.
// Depends on sgc_pkg.
module sgc_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               req_stall,
  input logic                               rsp_valid,
  input logic                               rsp_stall,
  input logic [1:0]                         status,
  input logic [sgc_pkg::SIZE_W-1:0]         slot_size,
  input logic [sgc_pkg::OBJ_W-1:0]          objects_per_slab,
  input logic [sgc_pkg::ORD_W-1:0]          slab_order
);

  a_rst_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(slot_size)
      && $stable(objects_per_slab) && $stable(slab_order))
    else $error("stalled transaction changed");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != sgc_pkg::ST_OK |->
      slot_size == '0 && objects_per_slab == '0 && slab_order == '0)
    else $error("error transaction with nonzero geometry");

  a_ok_nonzero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == sgc_pkg::ST_OK |->
      slot_size != '0 && objects_per_slab != '0)
    else $error("ok transaction with empty geometry");

  a_drain_ready: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> !req_stall)
    else $error("request stalled with empty output");

endmodule

bind slab_geometry_calculator sgc_checker u_sgc_checker (.*);
